>>> design/ir_remote_pulse_train_decoder_defines.svh
// Assertion macros for the infrared remote decoder.
// Included by the modules that carry assertions; no other dependency.
`ifndef IR_REMOTE_PULSE_TRAIN_DECODER_DEFINES_SVH
`define IR_REMOTE_PULSE_TRAIN_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define IRD_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define IRD_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("assertion failed");
`else
`define IRD_ASSERT_IMPL(label, clk, rst_n, prop)
`define IRD_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

>>> design/ird_pkg.sv
// Shared types, codes and timing windows for the infrared remote decoder.
// No dependencies.
package ird_pkg;

    typedef struct packed {
        logic [15:0] duration_us;
        logic        frame_end;
    } ird_in_t;

    typedef struct packed {
        logic        decoded;
        logic [2:0]  protocol;
        logic [15:0] address;
        logic [7:0]  command;
        logic [5:0]  bit_count;
        logic        address_extended;
    } ird_out_t;

    // Classification of one duration against every window.
    typedef struct packed {
        logic       nec_lead;
        logic       nec_rpt;
        logic       nec_hdr;
        logic       nec_short;
        logic       nec_one;
        logic       sony_start;
        logic       sony_short;
        logic       sony_one;
        logic       rc5_t;
        logic       rc5_2t;
        logic [6:0] position;
        logic       frame_end;
    } ird_cls_t;

    localparam logic [2:0] PROTO_UNKNOWN    = 3'd0;
    localparam logic [2:0] PROTO_NEC        = 3'd1;
    localparam logic [2:0] PROTO_NEC_REPEAT = 3'd2;
    localparam logic [2:0] PROTO_SONY       = 3'd3;
    localparam logic [2:0] PROTO_RC5        = 3'd4;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] NEC_LEAD_LO   = 16'd6750;
    localparam logic [15:0] NEC_LEAD_HI   = 16'd11250;
    localparam logic [15:0] NEC_RPT_LO    = 16'd1688;
    localparam logic [15:0] NEC_RPT_HI    = 16'd2812;
    localparam logic [15:0] NEC_HDR_LO    = 16'd3600;
    localparam logic [15:0] NEC_HDR_HI    = 16'd5400;
    localparam logic [15:0] NEC_SHORT_LO  = 16'd336;
    localparam logic [15:0] NEC_SHORT_HI  = 16'd784;
    localparam logic [15:0] NEC_ONE_LO    = 16'd1268;
    localparam logic [15:0] NEC_ONE_HI    = 16'd2112;
    localparam logic [15:0] SONY_START_LO = 16'd1800;
    localparam logic [15:0] SONY_START_HI = 16'd3000;
    localparam logic [15:0] SONY_SHORT_LO = 16'd390;
    localparam logic [15:0] SONY_SHORT_HI = 16'd810;
    localparam logic [15:0] SONY_ONE_LO   = 16'd840;
    localparam logic [15:0] SONY_ONE_HI   = 16'd1560;
    localparam logic [15:0] RC5_T_LO      = 16'd623;
    localparam logic [15:0] RC5_T_HI      = 16'd1155;
    localparam logic [15:0] RC5_2T_LO     = 16'd1245;
    localparam logic [15:0] RC5_2T_HI     = 16'd2311;

endpackage

>>> design/ird_front.sv
// Front end: takes duration beats, tracks frame position and classifies.
// Depends on ird_pkg.
module ird_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ird_pkg::ird_in_t  in_data,
    input  logic              q_full,
    output logic              in_stall,
    output logic              q_push,
    output ird_pkg::ird_cls_t q_data
);
    import ird_pkg::*;

    logic [6:0] pos_reg, pos_next;
    logic [15:0] d;

    function automatic logic win(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
        win = (v >= lo) && (v <= hi);
    endfunction

    assign d = in_data.duration_us;
    assign in_stall = q_full;
    assign q_push = in_valid && !q_full;

    // Classify the duration against every protocol window.
    always_comb
    begin
        q_data.nec_lead   = win(d, NEC_LEAD_LO, NEC_LEAD_HI);
        q_data.nec_rpt    = win(d, NEC_RPT_LO, NEC_RPT_HI);
        q_data.nec_hdr    = win(d, NEC_HDR_LO, NEC_HDR_HI);
        q_data.nec_short  = win(d, NEC_SHORT_LO, NEC_SHORT_HI);
        q_data.nec_one    = win(d, NEC_ONE_LO, NEC_ONE_HI);
        q_data.sony_start = win(d, SONY_START_LO, SONY_START_HI);
        q_data.sony_short = win(d, SONY_SHORT_LO, SONY_SHORT_HI);
        q_data.sony_one   = win(d, SONY_ONE_LO, SONY_ONE_HI);
        q_data.rc5_t      = win(d, RC5_T_LO, RC5_T_HI);
        q_data.rc5_2t     = win(d, RC5_2T_LO, RC5_2T_HI);
        q_data.position   = pos_reg;
        q_data.frame_end  = in_data.frame_end;
    end

    // Position within the frame, saturating, cleared after the last beat.
    always_comb
    begin
        pos_next = pos_reg;
        if (q_push)
        begin
            if (in_data.frame_end)
                pos_next = '0;
            else if (pos_reg != 7'h7f)
                pos_next = pos_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end
endmodule

>>> design/ird_queue.sv
// Short queue between the classifier and the recognizers.
// Depends on ird_pkg and the shared macro header.
module ird_queue #(
    parameter int DEPTH = ird_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ird_pkg::ird_cls_t push_data,
    output logic              full,
    output logic              not_empty,
    input  logic              pop,
    output ird_pkg::ird_cls_t pop_data
);
    import ird_pkg::*;
    `include "ir_remote_pulse_train_decoder_defines.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ird_cls_t mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == (AW+1)'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + AW'(1);
        if (pop)
            rd_next = (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + AW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + (AW+1)'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - (AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    `IRD_ASSERT_IMPL(a_no_overflow, clk, rst_n, !(push && full && !pop))
    `IRD_ASSERT_IMPL(a_no_underflow, clk, rst_n, !(pop && !not_empty))
    `IRD_ASSERT_IMPL(a_cnt_range, clk, rst_n, cnt_reg <= (AW+1)'(DEPTH))
endmodule

>>> design/ird_back.sv
// Back end: NEC, Sony and RC5 recognizers plus the result register.
// Depends on ird_pkg and the shared macro header.
module ird_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  ird_pkg::ird_cls_t q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output ird_pkg::ird_out_t out_data
);
    import ird_pkg::*;
    `include "ir_remote_pulse_train_decoder_defines.svh"

    logic [31:0] nec_bits_reg, nec_bits_next;
    logic        nec_alive_reg, nec_alive_next;
    logic        nec_rpt_reg, nec_rpt_next;
    logic [19:0] sony_bits_reg, sony_bits_next;
    logic [4:0]  sony_cnt_reg, sony_cnt_next;
    logic        sony_stop_reg, sony_stop_next;
    logic        sony_alive_reg, sony_alive_next;
    logic [29:0] rc5_lv_reg, rc5_lv_next;
    logic [4:0]  rc5_cnt_reg, rc5_cnt_next;
    logic        rc5_alive_reg, rc5_alive_next;
    logic        ov_reg, ov_next;
    ird_out_t    od_reg, od_next;

    logic [6:0]  p;
    logic        take, lvl;
    logic [4:0]  nec_idx;
    logic [13:0] rc5_val;
    logic        rc5_pair_ok, rc5_ok;
    logic [4:0]  rc5_cnt_fin;

    // Only a frame end has to wait for a free result register.
    assign p       = q_data.position;
    assign take    = q_valid && (!q_data.frame_end || !ov_reg || !out_stall);
    assign q_pop   = take;
    assign nec_idx = 5'((p - 7'd3) >> 1);
    assign lvl     = !p[0];

    // Recognizer updates for one classified beat.
    always_comb
    begin
        nec_bits_next   = nec_bits_reg;
        nec_alive_next  = nec_alive_reg;
        nec_rpt_next    = nec_rpt_reg;
        sony_bits_next  = sony_bits_reg;
        sony_cnt_next   = sony_cnt_reg;
        sony_stop_next  = sony_stop_reg;
        sony_alive_next = sony_alive_reg;
        rc5_lv_next     = rc5_lv_reg;
        rc5_cnt_next    = rc5_cnt_reg;
        rc5_alive_next  = rc5_alive_reg;
        if (nec_alive_reg)
        begin
            if (p == 7'd0)
            begin
                if (!q_data.nec_lead)
                    nec_alive_next = 1'b0;
            end
            else if (p == 7'd1)
            begin
                if (q_data.nec_rpt)
                    nec_rpt_next = 1'b1;
                else if (!q_data.nec_hdr)
                    nec_alive_next = 1'b0;
            end
            else if (!nec_rpt_reg && p <= 7'd65)
            begin
                if (!p[0])
                begin
                    if (!q_data.nec_short)
                        nec_alive_next = 1'b0;
                end
                else if (q_data.nec_one)
                    nec_bits_next[nec_idx] = 1'b1;
                else if (!q_data.nec_short)
                    nec_alive_next = 1'b0;
            end
        end
        if (sony_alive_reg)
        begin
            if (p == 7'd0)
            begin
                if (!q_data.sony_start)
                    sony_alive_next = 1'b0;
            end
            else if (p == 7'd1)
            begin
                if (!q_data.sony_short)
                    sony_alive_next = 1'b0;
            end
            else if (!p[0] && !sony_stop_reg && sony_cnt_reg < 5'd20)
            begin
                if (q_data.sony_one)
                begin
                    sony_bits_next[sony_cnt_reg] = 1'b1;
                    sony_cnt_next = sony_cnt_reg + 5'd1;
                end
                else if (q_data.sony_short)
                    sony_cnt_next = sony_cnt_reg + 5'd1;
                else
                    sony_stop_next = 1'b1;
            end
        end
        if (rc5_alive_reg)
        begin
            if (!q_data.rc5_t && !q_data.rc5_2t)
                rc5_alive_next = 1'b0;
            else if (rc5_cnt_reg >= 5'd30)
                rc5_alive_next = 1'b0;
            else
            begin
                rc5_lv_next[rc5_cnt_reg] = lvl;
                if (q_data.rc5_t)
                    rc5_cnt_next = rc5_cnt_reg + 5'd1;
                else if (rc5_cnt_reg >= 5'd29)
                    rc5_alive_next = 1'b0;
                else
                begin
                    rc5_lv_next[rc5_cnt_reg + 5'd1] = lvl;
                    rc5_cnt_next = rc5_cnt_reg + 5'd2;
                end
            end
        end
    end

    // RC5 bi-phase check on the updated half-bit levels.
    always_comb
    begin
        rc5_pair_ok = 1'b1;
        for (int k = 0; k < 14; k++)
        begin
            if (rc5_lv_next[2*k] == rc5_lv_next[2*k+1])
                rc5_pair_ok = 1'b0;
            rc5_val[13-k] = rc5_lv_next[2*k+1];
        end
        rc5_cnt_fin = (rc5_cnt_next == 5'd27) ? 5'd28 : rc5_cnt_next;
        rc5_ok = rc5_alive_next && (p != 7'd0) && (rc5_cnt_fin == 5'd28)
                 && rc5_pair_ok && rc5_val[13];
    end

    // Result selection, priority NEC repeat/NEC, Sony, RC5.
    always_comb
    begin
        od_next = '0;
        if (nec_alive_next && nec_rpt_next && p != 7'd0)
        begin
            od_next.decoded  = 1'b1;
            od_next.protocol = PROTO_NEC_REPEAT;
        end
        else if (nec_alive_next && !nec_rpt_next && p >= 7'd65
                 && ((nec_bits_next[23:16] ^ nec_bits_next[31:24]) == 8'hff))
        begin
            od_next.decoded   = 1'b1;
            od_next.protocol  = PROTO_NEC;
            od_next.command   = nec_bits_next[23:16];
            od_next.bit_count = 6'd32;
            if ((nec_bits_next[7:0] ^ nec_bits_next[15:8]) == 8'hff)
                od_next.address = {8'h00, nec_bits_next[7:0]};
            else
            begin
                od_next.address          = nec_bits_next[15:0];
                od_next.address_extended = 1'b1;
            end
        end
        else if (sony_alive_next && p != 7'd0 && (sony_cnt_next == 5'd12
                 || sony_cnt_next == 5'd15 || sony_cnt_next == 5'd20))
        begin
            od_next.decoded   = 1'b1;
            od_next.protocol  = PROTO_SONY;
            od_next.address   = {3'b000, sony_bits_next[19:7]};
            od_next.command   = {1'b0, sony_bits_next[6:0]};
            od_next.bit_count = {1'b0, sony_cnt_next};
        end
        else if (rc5_ok)
        begin
            od_next.decoded   = 1'b1;
            od_next.protocol  = PROTO_RC5;
            od_next.address   = {11'd0, rc5_val[10:6]};
            od_next.command   = {1'b0, !rc5_val[12], rc5_val[5:0]};
            od_next.bit_count = 6'd14;
        end
    end

    // Recognizer state; a frame end returns everything to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nec_bits_reg   <= '0;
            nec_alive_reg  <= 1'b1;
            nec_rpt_reg    <= 1'b0;
            sony_bits_reg  <= '0;
            sony_cnt_reg   <= '0;
            sony_stop_reg  <= 1'b0;
            sony_alive_reg <= 1'b1;
            rc5_lv_reg     <= '0;
            rc5_cnt_reg    <= 5'd1;
            rc5_alive_reg  <= 1'b1;
        end
        else if (take && q_data.frame_end)
        begin
            nec_bits_reg   <= '0;
            nec_alive_reg  <= 1'b1;
            nec_rpt_reg    <= 1'b0;
            sony_bits_reg  <= '0;
            sony_cnt_reg   <= '0;
            sony_stop_reg  <= 1'b0;
            sony_alive_reg <= 1'b1;
            rc5_lv_reg     <= '0;
            rc5_cnt_reg    <= 5'd1;
            rc5_alive_reg  <= 1'b1;
        end
        else if (take)
        begin
            nec_bits_reg   <= nec_bits_next;
            nec_alive_reg  <= nec_alive_next;
            nec_rpt_reg    <= nec_rpt_next;
            sony_bits_reg  <= sony_bits_next;
            sony_cnt_reg   <= sony_cnt_next;
            sony_stop_reg  <= sony_stop_next;
            sony_alive_reg <= sony_alive_next;
            rc5_lv_reg     <= rc5_lv_next;
            rc5_cnt_reg    <= rc5_cnt_next;
            rc5_alive_reg  <= rc5_alive_next;
        end
    end

    // Output register, refilled as soon as the held beat leaves.
    always_comb
    begin
        ov_next = ov_reg && out_stall;
        if (take && q_data.frame_end)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= ov_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && q_data.frame_end)
            od_reg <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    `IRD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `IRD_ASSERT_IMPL(a_fail_zero, clk, rst_n,
        !(out_valid && !out_data.decoded) || (out_data == '0))
    `IRD_ASSERT_IMPL(a_rc5_cnt, clk, rst_n, rc5_cnt_reg <= 5'd30 && sony_cnt_reg <= 5'd20)
endmodule

>>> design/ir_remote_pulse_train_decoder.sv
// Infrared remote decoder (NEC, Sony SIRC, RC5): each input beat is one mark or
// space duration in microseconds, the first of a frame a mark; the beat flagged
// frame_end yields one result beat and resets all recognizers. One duration is
// accepted per clock unless the queue is full: a classifier compares it against
// every window, a two-entry queue hands it to the recognizers, and a result
// register lets the next frame proceed while a result waits. The last duration
// reaches its result through the queue entry and then the result register.
module ir_remote_pulse_train_decoder #(
    parameter int QUEUE_DEPTH = ird_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  ird_pkg::ird_in_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output ird_pkg::ird_out_t out_data
);
    import ird_pkg::*;

    logic     push, full, not_empty, pop;
    ird_cls_t push_data, pop_data;

    ird_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .q_full   (full),
        .in_stall (in_stall),
        .q_push   (push),
        .q_data   (push_data)
    );

    ird_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .not_empty (not_empty),
        .pop       (pop),
        .pop_data  (pop_data)
    );

    ird_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (not_empty),
        .q_data    (pop_data),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );
endmodule
